// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file, jsu_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define JSU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define JSU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== sv/jsu_pkg.sv =====
// Types, codes and helper functions for the JSON string unescaper.
// No dependencies.
package jsu_pkg;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_BODY = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] HEX_LAST = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] UTF8_LIM1 = 16'h0080;
    localparam logic [15:0] UTF8_LIM2 = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } out_t;

    // Results of one request: count, kind of the first, up to three bytes.
    typedef struct packed {
        logic [1:0] cnt;
        logic [1:0] kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } group_t;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== sv/jsu_decode.sv =====
// Literal state and per-request decode into a group of up to three results.
// Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  in_t    item,
    input  logic   load,
    output group_t group
);

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  hex_reg, hex_next;
    logic [15:0] cp_reg, cp_next;
    logic [4:0]  hv;
    logic [15:0] cp_new;
    logic [7:0]  c;

    always_comb begin
        c      = item.in_byte;
        hv     = hex_digit(c);
        cp_new = {cp_reg[11:0], hv[3:0]};
        mode_next = mode_reg;
        hex_next  = hex_reg;
        cp_next   = cp_reg;
        group      = '0;
        group.kind = KIND_BYTE;
        if (item.end_of_text) begin
            mode_next  = MODE_IDLE;
            hex_next   = 2'd0;
            cp_next    = 16'd0;
            group.cnt  = 2'd1;
            group.kind = KIND_ERR;
        end else begin
            case (mode_reg)
                MODE_IDLE: begin
                    if (c != CH_QUOTE) begin
                        hex_next   = 2'd0;
                        cp_next    = 16'd0;
                        group.cnt  = 2'd1;
                        group.kind = KIND_ERR;
                    end else begin
                        mode_next = MODE_BODY;
                    end
                end
                MODE_BODY: begin
                    if (c == CH_QUOTE) begin
                        mode_next  = MODE_IDLE;
                        group.cnt  = 2'd1;
                        group.kind = KIND_DONE;
                    end else if (c == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        group.cnt = 2'd1;
                        group.b0  = c;
                    end
                end
                MODE_ESC: begin
                    if (c == CH_U) begin
                        mode_next = MODE_HEX;
                        hex_next  = 2'd0;
                        cp_next   = 16'd0;
                    end else begin
                        mode_next = MODE_BODY;
                        group.cnt = 2'd1;
                        case (c)
                            CH_N:    group.b0 = 8'h0A;
                            CH_R:    group.b0 = 8'h0D;
                            CH_T:    group.b0 = 8'h09;
                            CH_B:    group.b0 = 8'h08;
                            CH_F:    group.b0 = 8'h0C;
                            default: group.b0 = c;
                        endcase
                    end
                end
                default: begin
                    if (!hv[4]) begin
                        mode_next  = MODE_IDLE;
                        hex_next   = 2'd0;
                        cp_next    = 16'd0;
                        group.cnt  = 2'd1;
                        group.kind = KIND_ERR;
                    end else if (hex_reg != HEX_LAST) begin
                        cp_next  = cp_new;
                        hex_next = hex_reg + 2'd1;
                    end else begin
                        mode_next = MODE_BODY;
                        hex_next  = 2'd0;
                        cp_next   = 16'd0;
                        if (cp_new < UTF8_LIM1) begin
                            group.cnt = 2'd1;
                            group.b0  = cp_new[7:0];
                        end else if (cp_new < UTF8_LIM2) begin
                            group.cnt = 2'd2;
                            group.b0  = UTF8_LEAD2 | {3'd0, cp_new[10:6]};
                            group.b1  = UTF8_CONT | {2'd0, cp_new[5:0]};
                        end else begin
                            group.cnt = 2'd3;
                            group.b0  = UTF8_LEAD3 | {4'd0, cp_new[15:12]};
                            group.b1  = UTF8_CONT | {2'd0, cp_new[11:6]};
                            group.b2  = UTF8_CONT | {2'd0, cp_new[5:0]};
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            hex_reg  <= 2'd0;
            cp_reg   <= 16'd0;
        end else if (load) begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            cp_reg   <= cp_next;
        end
    end

endmodule

// ===== sv/jsu_emit.sv =====
// Result register: holds a decoded group, hands out one result a cycle while m_ready.
// Depends on jsu_pkg.
module jsu_emit import jsu_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   load,
    input  group_t group,
    output logic   free,
    output logic   m_valid,
    input  logic   m_ready,
    output out_t   m_data
);

    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] kind_reg;
    logic [7:0] b0_reg, b1_reg, b2_reg;
    logic       take;

    assign m_valid = cnt_reg != 2'd0;
    assign take    = m_valid && m_ready;
    assign free    = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_comb begin
        case (idx_reg)
            2'd0:    m_data.out_byte = b0_reg;
            2'd1:    m_data.out_byte = b1_reg;
            default: m_data.out_byte = b2_reg;
        endcase
        m_data.kind = (idx_reg == 2'd0) ? kind_reg : KIND_BYTE;
        m_data.last = cnt_reg == 2'd1;
    end

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = group.cnt;
            idx_next = 2'd0;
        end else if (take) begin
            cnt_next = cnt_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= group.kind;
            b0_reg   <= group.b0;
            b1_reg   <= group.b1;
            b2_reg   <= group.b2;
        end
    end

endmodule

// ===== sv/json_string_unescaper_top.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    in_t  (in_byte, end_of_text)
// m_        out  m_valid/m_ready    out_t (out_byte, kind, last)
// One request per cycle while the result register is free; a request with N
// results holds the result register until all N are taken (N up to 3, three-byte UTF-8).
// A request passes through the input register, then the result register, to m_data.
// Reset is synchronous on aresetn and returns the literal decoder to idle.
// A stalled m_ready backs up through the input register to s_ready.
// Top level of the JSON string unescaper; depends on jsu_pkg, jsu_decode, jsu_emit.
module json_string_unescaper_top import jsu_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic   in_valid_reg, in_valid_next;
    in_t    in_data_reg;
    logic   free;
    logic   load;
    group_t group;

    assign load    = in_valid_reg && free;
    assign s_ready = !in_valid_reg || free;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    jsu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_data_reg),
        .load    (load),
        .group   (group)
    );

    jsu_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .group   (group),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sv/jsu_checker.sv =====
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jsu_checker import jsu_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    `JSU_ASSERT_ALWAYS(a_idle_after_reset, aclk, !$past(aresetn) |-> !m_valid)
    `JSU_ASSERT(a_valid_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `JSU_ASSERT(a_kind_legal, aclk, aresetn, m_valid |-> m_data.kind <= KIND_ERR)
    `JSU_ASSERT(a_status_last, aclk, aresetn,
        m_valid && m_data.kind != KIND_BYTE |-> m_data.last)
    `JSU_ASSERT(a_status_zero, aclk, aresetn,
        m_valid && m_data.kind != KIND_BYTE |-> m_data.out_byte == 8'd0)

endmodule

bind json_string_unescaper_top jsu_checker u_jsu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/tb_json_string_unescaper_top.sv =====
// Self-checking testbench for json_string_unescaper_top: directed requests, then random
// string literals under varying back-pressure, checked against a decoder or typed rows.
// Depends on jsu_pkg and json_string_unescaper_top.
module tb_json_string_unescaper_top;
    import jsu_pkg::*;

    localparam int NUM_DIR        = 28;
    localparam int ITEMS_PER_PASS = 134;
    localparam int HOLD_CYCLES    = 80;
    localparam int STALL_LIMIT    = 1000;
    localparam int EXP_DEPTH      = 64;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        logic [7:0] val;
        logic [1:0] kind;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // decoder state
    logic [1:0]  dec_mode    = MODE_IDLE;
    logic [1:0]  dec_hex_cnt = '0;
    logic [15:0] dec_cp      = '0;
    out_t        step_res [3];
    int          step_cnt;

    // expected results, written by the sender, read by the result check
    out_t exp_fifo [EXP_DEPTH];
    int   exp_wr        = 0;
    int   exp_rd        = 0;
    int   fail_count    = 0;
    int   items_sent    = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_reqs     = 0;
    int   hold_seen     = 0;
    int   hold_left     = 0;
    int   stall_cnt     = 0;

    logic [7:0]  esc_chars [8] = '{CH_N, CH_R, CH_T, CH_B, CH_F, CH_SLASH, CH_BSLASH, CH_QUOTE};
    logic [15:0] cp_corner [6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};

    dir_row_t directed_rows [0:NUM_DIR-1] = '{
        {8'hFF,     1'b1, 1'b1, 8'h00, KIND_ERR},   // end of text while idle
        {8'h00,     1'b0, 1'b1, 8'h00, KIND_ERR},   // no opening quote
        {8'hFF,     1'b0, 1'b1, 8'h00, KIND_ERR},
        {CH_QUOTE,  1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h00,     1'b0, 1'b1, 8'h00, KIND_BYTE},
        {8'hFF,     1'b0, 1'b1, 8'hFF, KIND_BYTE},
        {CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},
        {CH_N,      1'b0, 1'b1, 8'h0A, KIND_BYTE},
        {CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},   // \u007f, one byte
        {CH_U,      1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h30,     1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h30,     1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h37,     1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h66,     1'b0, 1'b0, 8'h00, KIND_BYTE},
        {CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},   // \uFffF, three bytes
        {CH_U,      1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h46,     1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h66,     1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h66,     1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h46,     1'b0, 1'b0, 8'h00, KIND_BYTE},
        {CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},   // bad hex digit
        {CH_U,      1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h30,     1'b0, 1'b0, 8'h00, KIND_BYTE},
        {8'h67,     1'b0, 1'b1, 8'h00, KIND_ERR},
        {CH_QUOTE,  1'b0, 1'b0, 8'h00, KIND_BYTE},   // end of text inside literal
        {8'h00,     1'b1, 1'b1, 8'h00, KIND_ERR},
        {CH_QUOTE,  1'b0, 1'b0, 8'h00, KIND_BYTE},   // empty literal
        {CH_QUOTE,  1'b0, 1'b1, 8'h00, KIND_DONE}
    };

    json_string_unescaper_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void push_result(input logic [7:0] val, input logic [1:0] k);
        step_res[step_cnt] = {val, k, 1'b0};
        step_cnt++;
    endfunction

    function automatic void exp_put(input out_t r);
        exp_fifo[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    function automatic void decoder_error();
        dec_mode    = MODE_IDLE;
        dec_hex_cnt = '0;
        dec_cp      = '0;
        push_result(8'h00, KIND_ERR);
    endfunction

    // Advances the decoder by one request; results land in step_res[0 .. step_cnt-1].
    function automatic void predict_unescape(input in_t req);
        int          v;
        logic [15:0] cp;
        logic [7:0]  c;
        c        = req.in_byte;
        step_cnt = 0;
        if (req.end_of_text) begin
            decoder_error();
        end else begin
            case (dec_mode)
                MODE_IDLE: begin
                    if (c != CH_QUOTE) decoder_error();
                    else dec_mode = MODE_BODY;
                end
                MODE_BODY: begin
                    if (c == CH_QUOTE) begin
                        dec_mode = MODE_IDLE;
                        push_result(8'h00, KIND_DONE);
                    end else if (c == CH_BSLASH) begin
                        dec_mode = MODE_ESC;
                    end else begin
                        push_result(c, KIND_BYTE);
                    end
                end
                MODE_ESC: begin
                    dec_mode = MODE_BODY;
                    case (c)
                        CH_N: push_result(8'h0A, KIND_BYTE);
                        CH_R: push_result(8'h0D, KIND_BYTE);
                        CH_T: push_result(8'h09, KIND_BYTE);
                        CH_B: push_result(8'h08, KIND_BYTE);
                        CH_F: push_result(8'h0C, KIND_BYTE);
                        CH_U: begin
                            dec_mode    = MODE_HEX;
                            dec_hex_cnt = '0;
                            dec_cp      = '0;
                        end
                        default: push_result(c, KIND_BYTE);
                    endcase
                end
                default: begin
                    v = hex_nibble(c);
                    if (v < 0) begin
                        decoder_error();
                    end else begin
                        cp = {dec_cp[11:0], 4'(v)};
                        if (dec_hex_cnt != HEX_LAST) begin
                            dec_cp      = cp;
                            dec_hex_cnt = dec_hex_cnt + 2'd1;
                        end else begin
                            dec_mode    = MODE_BODY;
                            dec_hex_cnt = '0;
                            dec_cp      = '0;
                            if (cp < UTF8_LIM1) begin
                                push_result(cp[7:0], KIND_BYTE);
                            end else if (cp < UTF8_LIM2) begin
                                push_result(UTF8_LEAD2 | {3'b0, cp[10:6]}, KIND_BYTE);
                                push_result(UTF8_CONT | {2'b0, cp[5:0]}, KIND_BYTE);
                            end else begin
                                push_result(UTF8_LEAD3 | {4'b0, cp[15:12]}, KIND_BYTE);
                                push_result(UTF8_CONT | {2'b0, cp[11:6]}, KIND_BYTE);
                                push_result(UTF8_CONT | {2'b0, cp[5:0]}, KIND_BYTE);
                            end
                        end
                    end
                end
            endcase
        end
        if (step_cnt > 0) step_res[step_cnt-1].last = 1'b1;
    endfunction

    // Offers one request; a typed result replaces the decoder's prediction.
    task automatic send_req(input in_t req, input logic typed, input out_t typed_res);
        int k;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        predict_unescape(req);
        if (typed) begin
            exp_put(typed_res);
        end else begin
            for (k = 0; k < step_cnt; k++) exp_put(step_res[k]);
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        send_req({c, 1'b0}, 1'b0, '0);
    endtask

    task automatic send_hex_digits(input logic [15:0] cp, input int cnt);
        int         i;
        logic [3:0] nib;
        for (i = 0; i < cnt; i++) begin
            nib = cp[15 - 4*i -: 4];
            if (nib < 4'd10) send_char("0" + 8'(nib));
            else if ($urandom_range(1)) send_char("A" + 8'(nib) - 8'd10);
            else send_char("a" + 8'(nib) - 8'd10);
        end
    endtask

    task automatic send_literal();
        int          n_elem, k, sel;
        logic [15:0] cp;
        logic [7:0]  c;
        send_char(CH_QUOTE);
        n_elem = $urandom_range(6);
        for (k = 0; k < n_elem; k++) begin
            sel = $urandom_range(2);
            if (sel == 0) begin
                do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
                send_char(c);
            end else if (sel == 1) begin
                sel = $urandom_range(8);
                if (sel < 8) begin
                    c = esc_chars[sel];
                end else begin
                    do c = 8'($urandom); while (c == CH_U);
                end
                send_char(CH_BSLASH);
                send_char(c);
            end else begin
                case ($urandom_range(3))
                    0:       cp = 16'($urandom_range(16'h007F));
                    1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
                    2:       cp = 16'($urandom_range(16'hFFFF, 16'h0800));
                    default: cp = cp_corner[$urandom_range(5)];
                endcase
                send_char(CH_BSLASH);
                send_char(CH_U);
                send_hex_digits(cp, 4);
            end
        end
        sel = $urandom_range(19);
        if (sel < 16) begin
            send_char(CH_QUOTE);
        end else if (sel == 16) begin
            send_req({8'($urandom), 1'b1}, 1'b0, '0);
        end else if (sel == 17) begin
            send_char(CH_BSLASH);
            send_req({8'($urandom), 1'b1}, 1'b0, '0);
        end else begin
            send_char(CH_BSLASH);
            send_char(CH_U);
            send_hex_digits(16'($urandom), $urandom_range(3));
            if (sel == 18) begin
                send_req({8'($urandom), 1'b1}, 1'b0, '0);
            end else begin
                do c = 8'($urandom); while (hex_nibble(c) >= 0);
                send_char(c);
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (exp_wr != exp_rd);
    endtask

    // result check and receiver back-pressure
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_wr == exp_rd) begin
                $error("unexpected result: out_byte %h kind %0d last %0d",
                       m_data.out_byte, m_data.kind, m_data.last);
                fail_count++;
            end else begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, m_data.out_byte);
                    fail_count++;
                end
                if (m_data.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_data.kind);
                    fail_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_data.last);
                    fail_count++;
                end
            end
        end
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && !(s_valid && s_ready) && !(m_valid && m_ready)) stall_cnt++;
        else stall_cnt = 0;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("tb_json_string_unescaper_top NOT OK");
            $finish;
        end
    end

    initial begin
        int k, pass;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < NUM_DIR; k++) begin
            send_req({directed_rows[k].ch, directed_rows[k].eot}, directed_rows[k].typed,
                     {directed_rows[k].val, directed_rows[k].kind, 1'b1});
        end
        wait_drained();

        for (pass = 0; pass < 3; pass++) begin
            case (pass)
                0:       begin send_idle_pct = 37; recv_idle_pct = 68; end
                1:       begin send_idle_pct = 68; recv_idle_pct = 37; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            // long receiver hold while requests keep coming
            if (pass == 2) hold_reqs <= hold_reqs + 1;
            while (items_sent < NUM_DIR + (pass + 1) * ITEMS_PER_PASS) begin
                if ($urandom_range(99) < 85) send_literal();
                else send_req({8'($urandom), 1'($urandom_range(3) == 0)}, 1'b0, '0);
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_json_string_unescaper_top OK");
        end else begin
            $display("tb_json_string_unescaper_top NOT OK");
        end
        $finish;
    end

endmodule
